>>> hw/rtl/i64d_pkg.sv
// shared constants and types for the 64-bit signed/unsigned divider
// no dependencies
package i64d_pkg;

    localparam int I64D_FIELD_WIDTH = 64;
    localparam int I64D_DATA_WIDTH  = 64;
    localparam int I64D_FIFO_DEPTH  = 2;

    typedef struct packed {
        logic is_zero;
        logic q_neg;
        logic r_neg;
    } t_flags;

endpackage

>>> hw/rtl/i64d_front.sv
// front stage: accepts a transaction, takes operand magnitudes and classifies signs
// depends on i64d_pkg
module i64d_front
    import i64d_pkg::*;
#(
    parameter int DATA_WIDTH = I64D_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_mag_a,
    output logic [DATA_WIDTH-1:0] o_mag_b,
    output t_flags                o_flags
);

    logic                  r_vld;
    logic [DATA_WIDTH-1:0] r_mag_a;
    logic [DATA_WIDTH-1:0] r_mag_b;
    t_flags                r_flg;

    logic                  n_a_neg;
    logic                  n_b_neg;
    logic [DATA_WIDTH-1:0] n_mag_a;
    logic [DATA_WIDTH-1:0] n_mag_b;
    t_flags                n_flg;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        n_a_neg       = i_cmd && i_dividend[DATA_WIDTH-1];
        n_b_neg       = i_cmd && i_divisor[DATA_WIDTH-1];
        n_mag_a       = n_a_neg ? (~i_dividend + DATA_WIDTH'(1)) : i_dividend;
        n_mag_b       = n_b_neg ? (~i_divisor + DATA_WIDTH'(1)) : i_divisor;
        n_flg.is_zero = (i_divisor == '0);
        n_flg.q_neg   = n_a_neg ^ n_b_neg;
        n_flg.r_neg   = n_a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag_a <= n_mag_a;
            r_mag_b <= n_mag_b;
            r_flg   <= n_flg;
        end
    end

    assign o_valid = r_vld;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;
    assign o_flags = r_flg;

endmodule

>>> hw/rtl/i64d_fifo.sv
// short register queue between the front and the divider pipeline
// depends on i64d_pkg
module i64d_fifo
    import i64d_pkg::*;
#(
    parameter int WIDTH = 2 * I64D_DATA_WIDTH + $bits(t_flags),
    parameter int DEPTH = I64D_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic n_push;
    logic n_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign n_push  = i_valid && o_ready;
    assign n_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (n_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (n_pop && !n_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/i64d_back.sv
// back end: one restoring step per pipeline stage, then sign repair and output register
// depends on i64d_pkg
module i64d_back
    import i64d_pkg::*;
#(
    parameter int DATA_WIDTH = I64D_DATA_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [DATA_WIDTH-1:0]       i_mag_a,
    input  logic [DATA_WIDTH-1:0]       i_mag_b,
    input  t_flags                      i_flags,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [I64D_FIELD_WIDTH-1:0] o_quotient,
    output logic [I64D_FIELD_WIDTH-1:0] o_rem,
    output logic                        o_div_by_zero
);

    localparam int W = DATA_WIDTH;

    logic         r_vld [W];
    logic [W-1:0] r_rem [W];
    logic [W-1:0] r_nq  [W];
    logic [W-1:0] r_den [W];
    t_flags       r_flg [W];

    logic         r_out_vld;
    logic [W-1:0] r_quo_o;
    logic [W-1:0] r_rem_o;
    logic         r_dbz_o;

    logic         n_en;
    logic [W-1:0] n_quo;
    logic [W-1:0] n_rmd;

    assign n_en    = !r_out_vld || i_ready;
    assign o_ready = n_en;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic         n_vld_in;
        logic [W-1:0] n_rem_in;
        logic [W-1:0] n_nq_in;
        logic [W-1:0] n_den_in;
        t_flags       n_flg_in;
        logic [W-1:0] n_shift;
        logic [W-1:0] n_diff;
        logic         n_take;

        if (k == 0) begin : g_first
            assign n_vld_in = i_valid;
            assign n_rem_in = '0;
            assign n_nq_in  = i_mag_a;
            assign n_den_in = i_mag_b;
            assign n_flg_in = i_flags;
        end else begin : g_next
            assign n_vld_in = r_vld[k-1];
            assign n_rem_in = r_rem[k-1];
            assign n_nq_in  = r_nq[k-1];
            assign n_den_in = r_den[k-1];
            assign n_flg_in = r_flg[k-1];
        end

        // carry out of the shift means the partial remainder exceeds any divisor
        assign n_shift = {n_rem_in[W-2:0], n_nq_in[W-1]};
        assign n_diff  = n_shift - n_den_in;
        assign n_take  = n_rem_in[W-1] || (n_shift >= n_den_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (n_en) begin
                r_vld[k] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (n_en) begin
                r_rem[k] <= n_take ? n_diff : n_shift;
                r_nq[k]  <= {n_nq_in[W-2:0], n_take};
                r_den[k] <= n_den_in;
                r_flg[k] <= n_flg_in;
            end
        end
    end

    always_comb begin
        n_quo = r_flg[W-1].q_neg ? (~r_nq[W-1] + W'(1)) : r_nq[W-1];
        n_rmd = r_flg[W-1].r_neg ? (~r_rem[W-1] + W'(1)) : r_rem[W-1];
        if (r_flg[W-1].is_zero) begin
            n_quo = '0;
            n_rmd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (n_en) begin
            r_out_vld <= r_vld[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_quo_o <= n_quo;
            r_rem_o <= n_rmd;
            r_dbz_o <= r_flg[W-1].is_zero;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_quotient    = I64D_FIELD_WIDTH'(r_quo_o);
    assign o_rem         = I64D_FIELD_WIDTH'(r_rem_o);
    assign o_div_by_zero = r_dbz_o;

endmodule

>>> hw/rtl/int64_divider_signed_unsigned.sv
// top level of the signed/unsigned restoring divider: front, queue and pipelined back end
// depends on i64d_pkg, i64d_front, i64d_fifo and i64d_back
//
// Divides the low DATA_WIDTH bits of the dividend by those of the divisor, unsigned when
// tuser is 0 and two's-complement signed (truncating, remainder takes the dividend's sign)
// when tuser is 1. One division is accepted every cycle while the output side takes results;
// each passes the operand register, the queue, the chain of DATA_WIDTH restoring stages that
// each produce one quotient bit, and the sign-repair output register. A zero
// divisor returns zero quotient and remainder with the tuser flag set; the most negative
// value divided by minus one wraps to the most negative value. Results are zero-extended.
module int64_divider_signed_unsigned
    import i64d_pkg::*;
#(
    parameter int DATA_WIDTH = I64D_DATA_WIDTH,
    parameter int FIFO_DEPTH = I64D_FIFO_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*I64D_FIELD_WIDTH-1:0] s_axis_tdata,  // dividend, divisor
    input  logic                          s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [2*I64D_FIELD_WIDTH-1:0] m_axis_tdata,  // quotient, rem_out
    output logic                          m_axis_tuser   // div_by_zero
);

    localparam int Q_W = 2 * DATA_WIDTH + $bits(t_flags);

    logic                  fr_valid;
    logic                  fr_ready;
    logic [DATA_WIDTH-1:0] fr_mag_a;
    logic [DATA_WIDTH-1:0] fr_mag_b;
    t_flags                fr_flags;

    logic                  q_valid;
    logic                  q_ready;
    logic [Q_W-1:0]        q_data;

    logic [I64D_FIELD_WIDTH-1:0] bk_quo;
    logic [I64D_FIELD_WIDTH-1:0] bk_rem;

    i64d_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_dividend (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_divisor  (s_axis_tdata[I64D_FIELD_WIDTH+DATA_WIDTH-1:I64D_FIELD_WIDTH]),
        .o_valid    (fr_valid),
        .i_ready    (fr_ready),
        .o_mag_a    (fr_mag_a),
        .o_mag_b    (fr_mag_b),
        .o_flags    (fr_flags)
    );

    i64d_fifo #(
        .WIDTH (Q_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_data  ({fr_flags, fr_mag_b, fr_mag_a}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    i64d_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_mag_a       (q_data[DATA_WIDTH-1:0]),
        .i_mag_b       (q_data[2*DATA_WIDTH-1:DATA_WIDTH]),
        .i_flags       (t_flags'(q_data[Q_W-1:2*DATA_WIDTH])),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_quotient    (bk_quo),
        .o_rem         (bk_rem),
        .o_div_by_zero (m_axis_tuser)
    );

    assign m_axis_tdata = {bk_rem, bk_quo};

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench for int64_divider_signed_unsigned: directed and random divisions checked
// against a built-in restoring-division predictor, with random idling on both streams
// depends on i64d_pkg and the divider rtl
module testbench;

    import i64d_pkg::*;

    localparam int W              = I64D_DATA_WIDTH;
    localparam int FW             = I64D_FIELD_WIDTH;
    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;
    localparam int SETTLE_CYCLES  = W + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 500;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 410;
    localparam int HOLD_ITEMS     = 120;

    localparam logic [FW-1:0] ALL_ONES = '1;
    localparam logic [FW-1:0] MOST_NEG = {1'b1, {(FW-1){1'b0}}};
    localparam logic [FW-1:0] MOST_POS = {1'b0, {(FW-1){1'b1}}};

    typedef struct {
        logic          cmd;
        logic [FW-1:0] dividend;
        logic [FW-1:0] divisor;
        logic [FW-1:0] quotient;
        logic [FW-1:0] remainder;
        logic          div_by_zero;
    } t_division;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [2*FW-1:0] s_axis_tdata  = '0;  // dividend, divisor
    logic            s_axis_tuser  = 1'b0;  // cmd
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [2*FW-1:0] m_axis_tdata;  // quotient, rem_out
    logic            m_axis_tuser;  // div_by_zero

    t_division       pending_divisions[$];
    int              mismatch_count = 0;
    int              burst_left     = 0;
    int              hold_request   = 0;
    int              hold_left      = 0;
    int              pattern_age    = 0;
    logic [15:0]     stall_pattern  = '1;
    int              idle_cycles    = 0;

    int64_divider_signed_unsigned #(
        .DATA_WIDTH(W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_division predict_division(input logic cmd,
                                                   input logic [FW-1:0] dividend,
                                                   input logic [FW-1:0] divisor);
        t_division    res;
        logic [W-1:0] num;
        logic [W-1:0] den;
        logic [W-1:0] quo;
        logic [W:0]   part;
        logic         num_neg;
        logic         den_neg;
        res.cmd         = cmd;
        res.dividend    = dividend;
        res.divisor     = divisor;
        res.quotient    = '0;
        res.remainder   = '0;
        num             = dividend[W-1:0];
        den             = divisor[W-1:0];
        res.div_by_zero = (den == '0);
        if (!res.div_by_zero) begin
            num_neg = (cmd == CMD_SIGNED) && num[W-1];
            den_neg = (cmd == CMD_SIGNED) && den[W-1];
            if (num_neg) num = -num;
            if (den_neg) den = -den;
            part = '0;
            quo  = '0;
            // one quotient bit per step, carry kept in the top bit of the partial remainder
            for (int i = W - 1; i >= 0; i--) begin
                part = {part[W-1:0], num[i]};
                if (part >= {1'b0, den}) begin
                    part   = part - {1'b0, den};
                    quo[i] = 1'b1;
                end
            end
            if (num_neg != den_neg) quo = -quo;
            if (num_neg) part[W-1:0] = -part[W-1:0];
            res.quotient  = FW'(quo);
            res.remainder = FW'(part[W-1:0]);
        end
        return res;
    endfunction

    function automatic logic [FW-1:0] random_operand();
        logic [FW-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 6))
                    0: v = '0;
                    1: v = FW'(1);
                    2: v = ALL_ONES;
                    3: v = MOST_NEG;
                    4: v = MOST_POS;
                    5: v = MOST_NEG + 1'b1;
                    default: v = ALL_ONES - 1'b1;
                endcase
            end
            1, 2: v = v >> $urandom_range(1, FW - 1);
            3: v = -(v >> $urandom_range(1, FW - 1));
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_division(input logic cmd, input logic [FW-1:0] dividend,
                                 input logic [FW-1:0] divisor);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {divisor, dividend};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_divisions.push_back(predict_division(cmd, dividend, divisor));
    endtask

    task automatic send_random_division();
        logic [FW-1:0] divisor;
        divisor = ($urandom_range(0, 29) == 0) ? '0 : random_operand();
        send_division(1'($urandom), random_operand(), divisor);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_divisions.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_unsigned_directed();
        send_division(CMD_UNSIGNED, '0, FW'(1));
        send_division(CMD_UNSIGNED, ALL_ONES, FW'(1));
        send_division(CMD_UNSIGNED, ALL_ONES, ALL_ONES);
        send_division(CMD_UNSIGNED, ALL_ONES, MOST_NEG);
        send_division(CMD_UNSIGNED, MOST_NEG, ALL_ONES);
        send_division(CMD_UNSIGNED, MOST_NEG, FW'(3));
        send_division(CMD_UNSIGNED, ALL_ONES, FW'(2));
        send_division(CMD_UNSIGNED, FW'(12345), '0);
        send_division(CMD_UNSIGNED, '0, '0);
        send_division(CMD_UNSIGNED, FW'(5), FW'(7));
    endtask

    task automatic test_signed_directed();
        send_division(CMD_SIGNED, MOST_NEG, ALL_ONES);
        send_division(CMD_SIGNED, MOST_NEG, FW'(1));
        send_division(CMD_SIGNED, MOST_NEG, MOST_NEG);
        send_division(CMD_SIGNED, MOST_POS, MOST_NEG);
        send_division(CMD_SIGNED, MOST_NEG, MOST_POS);
        send_division(CMD_SIGNED, -FW'(7), FW'(2));
        send_division(CMD_SIGNED, FW'(7), -FW'(2));
        send_division(CMD_SIGNED, -FW'(7), -FW'(2));
        send_division(CMD_SIGNED, ALL_ONES, MOST_POS);
        send_division(CMD_SIGNED, '0, ALL_ONES);
        send_division(CMD_SIGNED, MOST_NEG, '0);
        send_division(CMD_SIGNED, MOST_POS, ALL_ONES);
        wait_for_drain();
    endtask

    task automatic test_output_backpressure();
        hold_request = LONG_HOLD;
        repeat (HOLD_ITEMS) send_random_division();
        wait_for_drain();
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            send_random_division();
            if (n == count / 2) wait_for_drain();
        end
    endtask

    // receiver: random ready pattern, periodically renewed, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                pattern_age   = $urandom_range(16, 96);
                stall_pattern = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
            end
            pattern_age--;
            m_axis_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    always @(posedge i_clk) begin : check_result
        t_division exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_divisions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transaction: q=%h r=%h z=%b",
                             m_axis_tdata[FW-1:0], m_axis_tdata[2*FW-1:FW], m_axis_tuser);
            end else begin
                exp = pending_divisions.pop_front();
                if (m_axis_tdata[FW-1:0] !== exp.quotient
                        || m_axis_tdata[2*FW-1:FW] !== exp.remainder
                        || m_axis_tuser !== exp.div_by_zero) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch cmd=%0d a=%h b=%h exp q=%h r=%h z=%b got q=%h r=%h z=%b",
                                 exp.cmd, exp.dividend, exp.divisor, exp.quotient,
                                 exp.remainder, exp.div_by_zero, m_axis_tdata[FW-1:0],
                                 m_axis_tdata[2*FW-1:FW], m_axis_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[int64_divider_signed_unsigned] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_unsigned_directed();
        test_signed_directed();
        test_output_backpressure();
        test_random_mix(RANDOM_ITEMS);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_divisions.size() == 0)
            $display("[int64_divider_signed_unsigned] OK");
        else
            $display("[int64_divider_signed_unsigned] ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/i64d_pkg.sv
hw/rtl/i64d_front.sv
hw/rtl/i64d_fifo.sv
hw/rtl/i64d_back.sv
hw/rtl/int64_divider_signed_unsigned.sv
sim/testbench.sv
